// ===== rtl/latex_math_tokenizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LaTeX math tokenizer
// Simulation-only concurrent checks; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef LATEX_MATH_TOKENIZER_TOP_ASSERT_SVH
`define LATEX_MATH_TOKENIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define LMT_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LMT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define LMT_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define LMT_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/lmt_pkg.sv =====
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types, codes and character classes of the LaTeX math tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmt_pkg;

    // Result field widths (fixed by the port list)
    localparam int KIND_W   = 5;
    localparam int LINE_W   = 16;
    localparam int COLUMN_W = 16;
    localparam int OFFSET_W = 32;
    localparam int LENGTH_W = 16;

    // Default counter widths
    localparam int DEF_LINE_BITS   = 16;
    localparam int DEF_COLUMN_BITS = 16;
    localparam int DEF_OFFSET_BITS = 32;
    localparam int DEF_LENGTH_BITS = 16;

    // Entries held between scanner and emitter
    localparam int QUEUE_DEPTH = 4;

    typedef logic [7:0]          t_byte;
    typedef logic [LINE_W-1:0]   t_line;
    typedef logic [COLUMN_W-1:0] t_column;
    typedef logic [OFFSET_W-1:0] t_offset;
    typedef logic [LENGTH_W-1:0] t_length;

    localparam t_byte CH_TAB     = 8'h09;
    localparam t_byte CH_NEWLINE = 8'h0A;
    localparam t_byte CH_SPACE   = 8'h20;
    localparam t_byte CH_PERCENT = 8'h25;
    localparam t_byte CH_DOT     = 8'h2E;
    localparam t_byte CH_LESS    = 8'h3C;
    localparam t_byte CH_EQUAL   = 8'h3D;
    localparam t_byte CH_GREATER = 8'h3E;
    localparam t_byte CH_BSLASH  = 8'h5C;

    typedef enum logic [KIND_W-1:0] {
        KIND_NUMBER     = 5'd0,
        KIND_IDENT      = 5'd1,
        KIND_COMMAND    = 5'd2,
        KIND_LBRACE     = 5'd3,
        KIND_RBRACE     = 5'd4,
        KIND_LPAREN     = 5'd5,
        KIND_RPAREN     = 5'd6,
        KIND_LBRACKET   = 5'd7,
        KIND_RBRACKET   = 5'd8,
        KIND_PLUS       = 5'd9,
        KIND_MINUS      = 5'd10,
        KIND_STAR       = 5'd11,
        KIND_SLASH      = 5'd12,
        KIND_CARET      = 5'd13,
        KIND_UNDERSCORE = 5'd14,
        KIND_AMP        = 5'd15,
        KIND_DOLLAR     = 5'd16,
        KIND_PUNCT      = 5'd17,
        KIND_SPACING    = 5'd18,
        KIND_EQUAL      = 5'd19,
        KIND_BANG       = 5'd20,
        KIND_LESS       = 5'd21,
        KIND_LESS_EQ    = 5'd22,
        KIND_GREATER    = 5'd23,
        KIND_GREATER_EQ = 5'd24,
        KIND_INVALID    = 5'd25,
        KIND_EOF        = 5'd26
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE      = 4'd0,
        MODE_INT       = 4'd1,
        MODE_FRAC      = 4'd2,
        MODE_IDENT     = 4'd3,
        MODE_CMD_START = 4'd4,
        MODE_CMD_WORD  = 4'd5,
        MODE_LESS      = 4'd6,
        MODE_GREATER   = 4'd7,
        MODE_COMMENT   = 4'd8
    } t_mode;

    typedef struct packed {
        t_kind   kind;
        t_line   line;
        t_column column;
        t_offset offset;
        t_length length;
    } t_token;

    // One accepted item: an optional flushed or completed token, then an optional second one
    typedef struct packed {
        logic   a_valid;
        t_token a;
        logic   b_valid;
        t_token b;
    } t_entry;

    function automatic logic is_digit(input t_byte b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input t_byte b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(input t_byte b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NEWLINE);
    endfunction

    // Single-character kinds; anything else is invalid
    function automatic t_kind single_kind(input t_byte b);
        t_kind k;
        unique case (b)
            8'h7B:                             k = KIND_LBRACE;
            8'h7D:                             k = KIND_RBRACE;
            8'h28:                             k = KIND_LPAREN;
            8'h29:                             k = KIND_RPAREN;
            8'h5B:                             k = KIND_LBRACKET;
            8'h5D:                             k = KIND_RBRACKET;
            8'h2B:                             k = KIND_PLUS;
            8'h2D:                             k = KIND_MINUS;
            8'h2A:                             k = KIND_STAR;
            8'h2F:                             k = KIND_SLASH;
            8'h5E:                             k = KIND_CARET;
            8'h5F:                             k = KIND_UNDERSCORE;
            8'h26:                             k = KIND_AMP;
            8'h24:                             k = KIND_DOLLAR;
            8'h27, 8'h2E, 8'h3A, 8'h3B, 8'h3F: k = KIND_PUNCT;
            8'h2C:                             k = KIND_SPACING;
            8'h3D:                             k = KIND_EQUAL;
            8'h21:                             k = KIND_BANG;
            default:                           k = KIND_INVALID;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/latex_math_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// latex_math_tokenizer_top: streaming tokenizer for LaTeX math source
// Path: an item's entry is written to the queue, then its tokens are loaded
// into the output register. Throughput: one byte per cycle in while the queue
// has room; one token per cycle out unless stalled, two-token items in turn.
// Reset: synchronous, active low; idle mode, line 1, column 1, offset 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module latex_math_tokenizer_top #(
    parameter int LINE_BITS   = lmt_pkg::DEF_LINE_BITS,
    parameter int COLUMN_BITS = lmt_pkg::DEF_COLUMN_BITS,
    parameter int OFFSET_BITS = lmt_pkg::DEF_OFFSET_BITS,
    parameter int LENGTH_BITS = lmt_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_opcode,
    input  wire logic [7:0]                i_source_byte,
    // Result channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [lmt_pkg::KIND_W-1:0]     o_token_kind,
    output logic [lmt_pkg::LINE_W-1:0]     o_token_line,
    output logic [lmt_pkg::COLUMN_W-1:0]   o_token_column,
    output logic [lmt_pkg::OFFSET_W-1:0]   o_start_offset,
    output logic [lmt_pkg::LENGTH_W-1:0]   o_token_length,
    output logic                           o_last_of_run
);

    // Front end: the scanner takes a byte whenever the queue has room, and
    // writes one entry (one or two tokens) per item that yields anything.
    // Back end: the emitter pops entries, one token per cycle unless stalled.
    logic             w_accept;
    logic             w_push, w_pop, w_full, w_empty;
    lmt_pkg::t_entry  w_entry, w_head;
    lmt_pkg::t_token  w_token;

    // Hold the input while the queue is full
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    lmt_scan #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_opcode      (i_opcode),
        .i_source_byte (i_source_byte),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    // Decouple scanner and emitter so that a two-token burst on the output
    // does not stop the byte stream.
    lmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lmt_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_token     (w_token),
        .o_last      (o_last_of_run)
    );

    // Break the output token into its fields
    assign o_token_kind   = w_token.kind;
    assign o_token_line   = w_token.line;
    assign o_token_column = w_token.column;
    assign o_start_offset = w_token.offset;
    assign o_token_length = w_token.length;

endmodule

`default_nettype wire

// ===== rtl/lmt_scan.sv =====
// ----------------------------------------------------------------------------
// lmt_scan
// Front end: scanner state, position counters and token formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "latex_math_tokenizer_top_assert.svh"

module lmt_scan #(
    parameter int LINE_BITS   = lmt_pkg::DEF_LINE_BITS,
    parameter int COLUMN_BITS = lmt_pkg::DEF_COLUMN_BITS,
    parameter int OFFSET_BITS = lmt_pkg::DEF_OFFSET_BITS,
    parameter int LENGTH_BITS = lmt_pkg::DEF_LENGTH_BITS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_opcode,
    input  wire lmt_pkg::t_byte  i_source_byte,
    output logic                 o_push,
    output lmt_pkg::t_entry      o_entry
);

    lmt_pkg::t_mode           r_mode, n_mode;
    logic [LINE_BITS-1:0]     r_line, n_line, r_pline, n_pline;
    logic [COLUMN_BITS-1:0]   r_col, n_col, r_pcol, n_pcol;
    logic [OFFSET_BITS-1:0]   r_off, n_off, r_poff, n_poff;
    logic [LENGTH_BITS-1:0]   r_plen, n_plen;

    logic                     w_digit, w_letter, w_newline, w_pending;
    logic                     w_extend, w_complete, w_flush, w_single, w_begin;
    lmt_pkg::t_mode           w_start_mode;
    logic [LINE_BITS-1:0]     w_line_inc;
    logic [COLUMN_BITS-1:0]   w_col_inc;
    logic [OFFSET_BITS-1:0]   w_off_inc;
    logic [LENGTH_BITS-1:0]   w_len_inc;

    // Saturating increments
    assign w_line_inc = (r_line == '1) ? r_line : r_line + LINE_BITS'(1);
    assign w_col_inc  = (r_col == '1)  ? r_col  : r_col + COLUMN_BITS'(1);
    assign w_off_inc  = (r_off == '1)  ? r_off  : r_off + OFFSET_BITS'(1);
    assign w_len_inc  = (r_plen == '1) ? r_plen : r_plen + LENGTH_BITS'(1);

    // Classify the byte against the current mode
    always_comb begin
        w_digit   = lmt_pkg::is_digit(i_source_byte);
        w_letter  = lmt_pkg::is_letter(i_source_byte);
        w_newline = (i_source_byte == lmt_pkg::CH_NEWLINE);
        w_pending = (r_mode != lmt_pkg::MODE_IDLE) && (r_mode != lmt_pkg::MODE_COMMENT);

        unique case (r_mode)
            lmt_pkg::MODE_INT:
                w_extend = w_digit || (i_source_byte == lmt_pkg::CH_DOT);
            lmt_pkg::MODE_FRAC:
                w_extend = w_digit;
            lmt_pkg::MODE_IDENT, lmt_pkg::MODE_CMD_WORD:
                w_extend = w_letter;
            lmt_pkg::MODE_CMD_START:
                w_extend = 1'b1;
            lmt_pkg::MODE_LESS, lmt_pkg::MODE_GREATER:
                w_extend = (i_source_byte == lmt_pkg::CH_EQUAL);
            default:
                w_extend = 1'b0;
        endcase

        w_complete = !i_opcode && w_extend &&
                     ((r_mode == lmt_pkg::MODE_CMD_START && !w_letter) ||
                      r_mode == lmt_pkg::MODE_LESS || r_mode == lmt_pkg::MODE_GREATER);
        w_flush    = w_pending && (i_opcode || !w_extend);

        // What the byte starts when it is scanned from idle
        w_begin = 1'b1;
        priority if (w_digit) begin
            w_start_mode = lmt_pkg::MODE_INT;
        end else if (w_letter) begin
            w_start_mode = lmt_pkg::MODE_IDENT;
        end else if (lmt_pkg::is_space(i_source_byte)) begin
            w_start_mode = lmt_pkg::MODE_IDLE;
            w_begin      = 1'b0;
        end else if (i_source_byte == lmt_pkg::CH_BSLASH) begin
            w_start_mode = lmt_pkg::MODE_CMD_START;
        end else if (i_source_byte == lmt_pkg::CH_LESS) begin
            w_start_mode = lmt_pkg::MODE_LESS;
        end else if (i_source_byte == lmt_pkg::CH_GREATER) begin
            w_start_mode = lmt_pkg::MODE_GREATER;
        end else if (i_source_byte == lmt_pkg::CH_PERCENT) begin
            w_start_mode = lmt_pkg::MODE_COMMENT;
            w_begin      = 1'b0;
        end else begin
            w_start_mode = lmt_pkg::MODE_IDLE;
        end

        w_single = !i_opcode && (r_mode != lmt_pkg::MODE_COMMENT) && !w_extend &&
                   w_begin && (w_start_mode == lmt_pkg::MODE_IDLE);
    end

    // Next state
    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_off   = r_off;
        n_pline = r_pline;
        n_pcol  = r_pcol;
        n_poff  = r_poff;
        n_plen  = r_plen;
        if (i_accept) begin
            if (i_opcode) begin
                n_mode  = lmt_pkg::MODE_IDLE;
                n_line  = LINE_BITS'(1);
                n_col   = COLUMN_BITS'(1);
                n_off   = '0;
                n_pline = '0;
                n_pcol  = '0;
                n_poff  = '0;
                n_plen  = '0;
            end else begin
                n_off  = w_off_inc;
                n_line = w_newline ? w_line_inc : r_line;
                n_col  = w_newline ? COLUMN_BITS'(1) : w_col_inc;
                if (r_mode == lmt_pkg::MODE_COMMENT) begin
                    if (w_newline) begin
                        n_mode = lmt_pkg::MODE_IDLE;
                    end
                end else if (w_extend) begin
                    n_plen = w_len_inc;
                    priority if (r_mode == lmt_pkg::MODE_INT &&
                                 i_source_byte == lmt_pkg::CH_DOT) begin
                        n_mode = lmt_pkg::MODE_FRAC;
                    end else if (r_mode == lmt_pkg::MODE_CMD_START && w_letter) begin
                        n_mode = lmt_pkg::MODE_CMD_WORD;
                    end else if (w_complete) begin
                        n_mode = lmt_pkg::MODE_IDLE;
                    end else begin
                        n_mode = r_mode;
                    end
                end else begin
                    n_mode = w_start_mode;
                    if (w_begin) begin
                        n_pline = r_line;
                        n_pcol  = r_col;
                        n_poff  = r_off;
                        n_plen  = LENGTH_BITS'(1);
                    end
                end
            end
        end
    end

    // Outputs: the flushed or completed token, then the token this item makes
    always_comb begin
        o_entry.a_valid   = w_flush || w_complete;
        o_entry.a.line    = lmt_pkg::t_line'(r_pline);
        o_entry.a.column  = lmt_pkg::t_column'(r_pcol);
        o_entry.a.offset  = lmt_pkg::t_offset'(r_poff);
        o_entry.a.length  = w_complete ? lmt_pkg::t_length'(w_len_inc)
                                       : lmt_pkg::t_length'(r_plen);
        unique case (r_mode)
            lmt_pkg::MODE_INT, lmt_pkg::MODE_FRAC:
                o_entry.a.kind = lmt_pkg::KIND_NUMBER;
            lmt_pkg::MODE_IDENT:
                o_entry.a.kind = lmt_pkg::KIND_IDENT;
            lmt_pkg::MODE_CMD_START, lmt_pkg::MODE_CMD_WORD:
                o_entry.a.kind = lmt_pkg::KIND_COMMAND;
            lmt_pkg::MODE_LESS:
                o_entry.a.kind = w_complete ? lmt_pkg::KIND_LESS_EQ : lmt_pkg::KIND_LESS;
            lmt_pkg::MODE_GREATER:
                o_entry.a.kind = w_complete ? lmt_pkg::KIND_GREATER_EQ
                                            : lmt_pkg::KIND_GREATER;
            default:
                o_entry.a.kind = lmt_pkg::KIND_INVALID;
        endcase

        o_entry.b_valid   = i_opcode || w_single;
        o_entry.b.kind    = i_opcode ? lmt_pkg::KIND_EOF
                                     : lmt_pkg::single_kind(i_source_byte);
        o_entry.b.line    = lmt_pkg::t_line'(r_line);
        o_entry.b.column  = lmt_pkg::t_column'(r_col);
        o_entry.b.offset  = lmt_pkg::t_offset'(r_off);
        o_entry.b.length  = i_opcode ? '0 : lmt_pkg::t_length'(1);

        o_push = i_accept && (o_entry.a_valid || o_entry.b_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lmt_pkg::MODE_IDLE;
            r_line  <= LINE_BITS'(1);
            r_col   <= COLUMN_BITS'(1);
            r_off   <= '0;
            r_pline <= '0;
            r_pcol  <= '0;
            r_poff  <= '0;
            r_plen  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_off   <= n_off;
            r_pline <= n_pline;
            r_pcol  <= n_pcol;
            r_poff  <= n_poff;
            r_plen  <= n_plen;
        end
    end

    // End marker returns the scanner to its reset position
    `LMT_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, i_accept && i_opcode, r_mode == lmt_pkg::MODE_IDLE && r_off == '0)

endmodule

`default_nettype wire

// ===== rtl/lmt_queue.sv =====
// ----------------------------------------------------------------------------
// lmt_queue
// Short entry queue between scanner and emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "latex_math_tokenizer_top_assert.svh"

module lmt_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lmt_pkg::t_entry  i_entry,
    input  wire logic             i_pop,
    output lmt_pkg::t_entry       o_head,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int DEPTH = lmt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lmt_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `LMT_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `LMT_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `LMT_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CNT_W'(1))

endmodule

`default_nettype wire

// ===== rtl/lmt_emit.sv =====
// ----------------------------------------------------------------------------
// lmt_emit
// Back end: splits queue entries into tokens behind an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "latex_math_tokenizer_top_assert.svh"

module lmt_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lmt_pkg::t_entry  i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    input  wire logic             i_out_stall,
    output logic                  o_out_valid,
    output lmt_pkg::t_token       o_token,
    output logic                  o_last
);

    logic             r_valid, n_valid;
    logic             r_last, n_last;
    logic             r_second_valid, n_second_valid;
    lmt_pkg::t_token  r_tok, n_tok;
    lmt_pkg::t_token  r_second, n_second;
    logic             w_load;

    // Output slot free or being taken this cycle
    assign w_load = !r_valid || !i_out_stall;
    assign o_pop  = w_load && !r_second_valid && !i_empty;

    always_comb begin
        n_valid        = r_valid;
        n_tok          = r_tok;
        n_last         = r_last;
        n_second_valid = r_second_valid;
        n_second       = r_second;
        if (w_load) begin
            priority if (r_second_valid) begin
                n_valid        = 1'b1;
                n_tok          = r_second;
                n_last         = 1'b1;
                n_second_valid = 1'b0;
            end else if (!i_empty) begin
                n_valid = 1'b1;
                if (i_head.a_valid) begin
                    n_tok          = i_head.a;
                    n_last         = !i_head.b_valid;
                    n_second_valid = i_head.b_valid;
                    n_second       = i_head.b;
                end else begin
                    n_tok  = i_head.b;
                    n_last = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_second_valid <= 1'b0;
        end else begin
            r_valid        <= n_valid;
            r_second_valid <= n_second_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok    <= n_tok;
        r_last   <= n_last;
        r_second <= n_second;
    end

    assign o_out_valid = r_valid;
    assign o_token     = r_tok;
    assign o_last      = r_last;

    // A held second token always sits behind a first one of the same item
    `LMT_ASSERT_SAME(a_second_behind, i_clk, i_rst_n, r_second_valid, r_valid && !r_last)
    `LMT_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_valid)

endmodule

`default_nettype wire

// ===== tb/latex_math_tokenizer_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// latex_math_tokenizer_tb_pkg
// Opcodes of the tokenizer input item, shared by stimulus and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package latex_math_tokenizer_tb_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

endpackage

// ===== tb/latex_math_tokenizer_checker.sv =====
// ----------------------------------------------------------------------------
// latex_math_tokenizer_checker
// Watches both channels of the tokenizer, predicts the tokens of every
// accepted item and compares each accepted token field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module latex_math_tokenizer_checker #(
    parameter int LINE_BITS   = lmt_pkg::DEF_LINE_BITS,
    parameter int COLUMN_BITS = lmt_pkg::DEF_COLUMN_BITS,
    parameter int OFFSET_BITS = lmt_pkg::DEF_OFFSET_BITS,
    parameter int LENGTH_BITS = lmt_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_stall,
    input  wire logic                         i_opcode,
    input  wire logic [7:0]                   i_source_byte,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_stall,
    input  wire logic [lmt_pkg::KIND_W-1:0]   i_token_kind,
    input  wire logic [lmt_pkg::LINE_W-1:0]   i_token_line,
    input  wire logic [lmt_pkg::COLUMN_W-1:0] i_token_column,
    input  wire logic [lmt_pkg::OFFSET_W-1:0] i_start_offset,
    input  wire logic [lmt_pkg::LENGTH_W-1:0] i_token_length,
    input  wire logic                         i_last_of_run,
    output int                                o_fail_count,
    output int                                o_tokens_due
);

    localparam logic [63:0] LINE_MAX   = (64'd1 << LINE_BITS) - 64'd1;
    localparam logic [63:0] COLUMN_MAX = (64'd1 << COLUMN_BITS) - 64'd1;
    localparam logic [63:0] OFFSET_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam logic [63:0] LENGTH_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

    typedef struct packed {
        lmt_pkg::t_token tok;
        logic            last;
    } t_due_token;

    lmt_pkg::t_mode  scan_mode;
    logic [63:0]     line_now, column_now, offset_now;
    logic [63:0]     tok_line, tok_column, tok_offset, tok_length;
    lmt_pkg::t_token item_tokens[$];
    t_due_token      tokens_due[$];
    int              fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic is_num(input lmt_pkg::t_byte b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input lmt_pkg::t_byte b);
        return (b | 8'h20) inside {[8'h61:8'h7A]};
    endfunction

    function automatic lmt_pkg::t_kind lone_kind(input lmt_pkg::t_byte b);
        case (b)
            "{":                     return lmt_pkg::KIND_LBRACE;
            "}":                     return lmt_pkg::KIND_RBRACE;
            "(":                     return lmt_pkg::KIND_LPAREN;
            ")":                     return lmt_pkg::KIND_RPAREN;
            "[":                     return lmt_pkg::KIND_LBRACKET;
            "]":                     return lmt_pkg::KIND_RBRACKET;
            "+":                     return lmt_pkg::KIND_PLUS;
            "-":                     return lmt_pkg::KIND_MINUS;
            "*":                     return lmt_pkg::KIND_STAR;
            "/":                     return lmt_pkg::KIND_SLASH;
            "^":                     return lmt_pkg::KIND_CARET;
            "_":                     return lmt_pkg::KIND_UNDERSCORE;
            "&":                     return lmt_pkg::KIND_AMP;
            "$":                     return lmt_pkg::KIND_DOLLAR;
            "'", ".", ":", ";", "?": return lmt_pkg::KIND_PUNCT;
            ",":                     return lmt_pkg::KIND_SPACING;
            "=":                     return lmt_pkg::KIND_EQUAL;
            "!":                     return lmt_pkg::KIND_BANG;
            default:                 return lmt_pkg::KIND_INVALID;
        endcase
    endfunction

    function automatic void clear_scanner();
        scan_mode  = lmt_pkg::MODE_IDLE;
        line_now   = 64'd1;
        column_now = 64'd1;
        offset_now = 64'd0;
        tok_line   = 64'd0;
        tok_column = 64'd0;
        tok_offset = 64'd0;
        tok_length = 64'd0;
    endfunction

    function automatic void step_position(input lmt_pkg::t_byte b);
        if (offset_now < OFFSET_MAX) offset_now++;
        if (b == lmt_pkg::CH_NEWLINE) begin
            if (line_now < LINE_MAX) line_now++;
            column_now = 64'd1;
        end else if (column_now < COLUMN_MAX) begin
            column_now++;
        end
    endfunction

    function automatic void open_token(input lmt_pkg::t_mode m);
        tok_line   = line_now;
        tok_column = column_now;
        tok_offset = offset_now;
        tok_length = 64'd0;
        scan_mode  = m;
    endfunction

    function automatic void consume(input lmt_pkg::t_byte b);
        step_position(b);
        if (tok_length < LENGTH_MAX) tok_length++;
    endfunction

    function automatic void close_token(input lmt_pkg::t_kind k);
        lmt_pkg::t_token t;
        t.kind   = k;
        t.line   = lmt_pkg::t_line'(tok_line);
        t.column = lmt_pkg::t_column'(tok_column);
        t.offset = lmt_pkg::t_offset'(tok_offset);
        t.length = lmt_pkg::t_length'(tok_length);
        item_tokens = {item_tokens, t};
        scan_mode = lmt_pkg::MODE_IDLE;
    endfunction

    // A byte seen with nothing pending
    function automatic void scan_fresh(input lmt_pkg::t_byte b);
        if (is_num(b)) begin
            open_token(lmt_pkg::MODE_INT);
            consume(b);
        end else if (is_alpha(b)) begin
            open_token(lmt_pkg::MODE_IDENT);
            consume(b);
        end else if (b == lmt_pkg::CH_SPACE || b == lmt_pkg::CH_TAB ||
                     b == lmt_pkg::CH_NEWLINE) begin
            step_position(b);
        end else if (b == lmt_pkg::CH_BSLASH) begin
            open_token(lmt_pkg::MODE_CMD_START);
            consume(b);
        end else if (b == lmt_pkg::CH_LESS) begin
            open_token(lmt_pkg::MODE_LESS);
            consume(b);
        end else if (b == lmt_pkg::CH_GREATER) begin
            open_token(lmt_pkg::MODE_GREATER);
            consume(b);
        end else if (b == lmt_pkg::CH_PERCENT) begin
            scan_mode = lmt_pkg::MODE_COMMENT;
            step_position(b);
        end else begin
            open_token(lmt_pkg::MODE_IDLE);
            consume(b);
            close_token(lone_kind(b));
        end
    endfunction

    function automatic void flush_pending();
        case (scan_mode)
            lmt_pkg::MODE_INT, lmt_pkg::MODE_FRAC:
                close_token(lmt_pkg::KIND_NUMBER);
            lmt_pkg::MODE_IDENT:
                close_token(lmt_pkg::KIND_IDENT);
            lmt_pkg::MODE_CMD_START, lmt_pkg::MODE_CMD_WORD:
                close_token(lmt_pkg::KIND_COMMAND);
            lmt_pkg::MODE_LESS:
                close_token(lmt_pkg::KIND_LESS);
            lmt_pkg::MODE_GREATER:
                close_token(lmt_pkg::KIND_GREATER);
            default:
                scan_mode = lmt_pkg::MODE_IDLE;
        endcase
    endfunction

    function automatic void tokenize_item(input logic op, input lmt_pkg::t_byte b);
        t_due_token entry;
        item_tokens.delete();
        if (op == latex_math_tokenizer_tb_pkg::OP_END) begin
            flush_pending();
            tok_line   = line_now;
            tok_column = column_now;
            tok_offset = offset_now;
            tok_length = 64'd0;
            close_token(lmt_pkg::KIND_EOF);
            clear_scanner();
        end else begin
            case (scan_mode)
                lmt_pkg::MODE_INT: begin
                    if (is_num(b)) begin
                        consume(b);
                    end else if (b == lmt_pkg::CH_DOT) begin
                        consume(b);
                        scan_mode = lmt_pkg::MODE_FRAC;
                    end else begin
                        flush_pending();
                        scan_fresh(b);
                    end
                end
                lmt_pkg::MODE_FRAC: begin
                    if (is_num(b)) begin
                        consume(b);
                    end else begin
                        flush_pending();
                        scan_fresh(b);
                    end
                end
                lmt_pkg::MODE_IDENT, lmt_pkg::MODE_CMD_WORD: begin
                    if (is_alpha(b)) begin
                        consume(b);
                    end else begin
                        flush_pending();
                        scan_fresh(b);
                    end
                end
                lmt_pkg::MODE_CMD_START: begin
                    consume(b);
                    if (is_alpha(b)) scan_mode = lmt_pkg::MODE_CMD_WORD;
                    else close_token(lmt_pkg::KIND_COMMAND);
                end
                lmt_pkg::MODE_LESS, lmt_pkg::MODE_GREATER: begin
                    if (b == lmt_pkg::CH_EQUAL) begin
                        consume(b);
                        close_token(scan_mode == lmt_pkg::MODE_LESS ?
                                    lmt_pkg::KIND_LESS_EQ : lmt_pkg::KIND_GREATER_EQ);
                    end else begin
                        flush_pending();
                        scan_fresh(b);
                    end
                end
                lmt_pkg::MODE_COMMENT: begin
                    step_position(b);
                    if (b == lmt_pkg::CH_NEWLINE) scan_mode = lmt_pkg::MODE_IDLE;
                end
                default: begin
                    scan_mode = lmt_pkg::MODE_IDLE;
                    scan_fresh(b);
                end
            endcase
        end
        for (int i = 0; i < item_tokens.size(); i++) begin
            entry.tok  = item_tokens[i];
            entry.last = (i == item_tokens.size() - 1);
            tokens_due = {tokens_due, entry};
        end
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_due_token want;
        if (!i_rst_n) begin
            clear_scanner();
            tokens_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) tokenize_item(i_opcode, i_source_byte);
            if (i_out_valid && !i_out_stall) begin
                if (tokens_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected token, expected none, actual kind %0d at %0d",
                             $time, i_token_kind, i_start_offset);
                end else begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", want.tok.kind, i_token_kind);
                    check_field("token_line", want.tok.line, i_token_line);
                    check_field("token_column", want.tok.column, i_token_column);
                    check_field("start_offset", want.tok.offset, i_start_offset);
                    check_field("token_length", want.tok.length, i_token_length);
                    check_field("last_of_run", want.last, i_last_of_run);
                end
            end
        end
        o_tokens_due <= tokens_due.size();
    end

endmodule

// ===== tb/latex_math_tokenizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// latex_math_tokenizer_top_tb
// Feeds the tokenizer directed and random LaTeX math source with random
// gaps on both channels and long output hold-offs; the checker beside the
// block predicts every token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module latex_math_tokenizer_top_tb;

    localparam int STALL_LIMIT     = 2000;   // cycles with no item moving
    localparam int HOLD_OFF_CYCLES = 300;    // long receiver hold-off
    localparam int DRAIN_CYCLES    = 10;     // margin for a stray token before the verdict

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         opcode      = latex_math_tokenizer_tb_pkg::OP_BYTE;
    logic [7:0]                   source_byte = 8'h00;
    logic                         out_stall   = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic [lmt_pkg::KIND_W-1:0]   token_kind;
    logic [lmt_pkg::LINE_W-1:0]   token_line;
    logic [lmt_pkg::COLUMN_W-1:0] token_column;
    logic [lmt_pkg::OFFSET_W-1:0] start_offset;
    logic [lmt_pkg::LENGTH_W-1:0] token_length;
    logic                         last_of_run;

    int   fail_count;
    int   tokens_due;
    int   sent_items    = 0;
    int   hold_requests = 0;
    logic quiet_mode    = 1'b0;   // no idling on either side while set

    // 4 ns period
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    latex_math_tokenizer_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_source_byte  (source_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_token_kind   (token_kind),
        .o_token_line   (token_line),
        .o_token_column (token_column),
        .o_start_offset (start_offset),
        .o_token_length (token_length),
        .o_last_of_run  (last_of_run)
    );

    latex_math_tokenizer_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_source_byte  (source_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_token_kind   (token_kind),
        .i_token_line   (token_line),
        .i_token_column (token_column),
        .i_start_offset (start_offset),
        .i_token_length (token_length),
        .i_last_of_run  (last_of_run),
        .o_fail_count   (fail_count),
        .o_tokens_due   (tokens_due)
    );

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (quiet_mode) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic lmt_pkg::t_byte pick_digit();
        return lmt_pkg::t_byte'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic lmt_pkg::t_byte pick_letter();
        return lmt_pkg::t_byte'(($urandom_range(0, 1) ? 8'h41 : 8'h61) +
                                $urandom_range(0, 25));
    endfunction

    // Idle for a random gap, then offer the item and hold it until taken.
    // Valid stays high when the next item follows without a gap.
    task automatic send_item(input logic op, input lmt_pkg::t_byte value);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        opcode      <= op;
        source_byte <= value;
        do @(posedge clk); while (in_stall);
        sent_items++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::t_byte'(text[i]));
        end
    endtask

    // Drop valid and wait for every predicted token to come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tokens_due != 0) @(posedge clk);
    endtask

    // One lexeme of plausible source: mostly well formed, some noise bytes
    // and the odd end marker in the middle of the stream
    task automatic send_lexeme();
        int             pick;
        int             n;
        lmt_pkg::t_byte b;
        string          singles = "{}()[]+-*/^_&$'.:;?,=!";
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, pick_digit());
            if ($urandom_range(0, 2) == 0) begin
                send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::CH_DOT);
                n = $urandom_range(0, 3);
                repeat (n) send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, pick_digit());
            end
        end else if (pick < 28) begin
            n = $urandom_range(1, 8);
            repeat (n) send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, pick_letter());
        end else if (pick < 38) begin
            // command word; no letters leaves a lone backslash for the next lexeme
            send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::CH_BSLASH);
            n = $urandom_range(0, 6);
            repeat (n) send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, pick_letter());
        end else if (pick < 45) begin
            send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::CH_BSLASH);
            do b = lmt_pkg::t_byte'($urandom_range(0, 255));
            while ((b | 8'h20) inside {[8'h61:8'h7A]});
            send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, b);
        end else if (pick < 61) begin
            send_item(latex_math_tokenizer_tb_pkg::OP_BYTE,
                      lmt_pkg::t_byte'(singles[$urandom_range(0, singles.len() - 1)]));
        end else if (pick < 69) begin
            send_item(latex_math_tokenizer_tb_pkg::OP_BYTE,
                      $urandom_range(0, 1) ? lmt_pkg::CH_LESS : lmt_pkg::CH_GREATER);
            if ($urandom_range(0, 1) == 1) begin
                send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::CH_EQUAL);
            end
        end else if (pick < 79) begin
            case ($urandom_range(0, 2))
                0:       send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::CH_SPACE);
                1:       send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::CH_TAB);
                default: send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::CH_NEWLINE);
            endcase
        end else if (pick < 84) begin
            send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::CH_PERCENT);
            n = $urandom_range(0, 6);
            repeat (n) begin
                do b = lmt_pkg::t_byte'($urandom_range(0, 255));
                while (b == lmt_pkg::CH_NEWLINE);
                send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, b);
            end
            send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, lmt_pkg::CH_NEWLINE);
        end else if (pick < 97) begin
            send_item(latex_math_tokenizer_tb_pkg::OP_BYTE,
                      lmt_pkg::t_byte'($urandom_range(0, 255)));
        end else begin
            send_item(latex_math_tokenizer_tb_pkg::OP_END,
                      lmt_pkg::t_byte'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random(input int count);
        int target;
        target = sent_items + count;
        while (sent_items < target) send_lexeme();
    endtask

    // Result side: random stalls, and a long hold-off on each request from
    // the stimulus, counted here so the sender keeps going meanwhile
    initial begin : receiver
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // Abort when neither channel moves an item for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        // Hold reset, then release it away from the rising edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a fractional number, >=, an identifier cut by <, backslash
        // before a zero byte, a newline and a space, a comment holding the
        // byte extremes, invalid bytes outside a comment, then a lone
        // backslash flushed by the end marker and a comment cut by it
        send_text("3.14>=ab<\\");
        send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, 8'h00);
        send_text("\\\n\\ %");
        send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, 8'h00);
        send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, 8'hFF);
        send_text("\n");
        send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, 8'hFF);
        send_item(latex_math_tokenizer_tb_pkg::OP_BYTE, 8'h00);
        send_text("\\");
        send_item(latex_math_tokenizer_tb_pkg::OP_END, 8'hFF);
        send_text("%");
        send_item(latex_math_tokenizer_tb_pkg::OP_END, 8'h00);
        wait_drained();

        // Random source while the receiver holds off: the block fills up and
        // must stall its input; then pause until every token is out
        hold_requests++;
        send_random(250);
        wait_drained();

        // Back-to-back stretch with no idling on either side
        quiet_mode = 1'b1;
        send_random(200);
        wait_drained();
        quiet_mode = 1'b0;

        // Random gaps again with a second hold-off
        hold_requests++;
        send_random(250);
        wait_drained();

        // Let any stray token show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lmt_pkg.sv
rtl/lmt_scan.sv
rtl/lmt_queue.sv
rtl/lmt_emit.sv
rtl/latex_math_tokenizer_top.sv
tb/latex_math_tokenizer_tb_pkg.sv
tb/latex_math_tokenizer_checker.sv
tb/latex_math_tokenizer_top_tb.sv
